/* sv/ial_pkg.sv */
// shared types and codes for the indexed insert/remove list
package ial_pkg;

	// fixed port widths
	localparam int OP_W  = 3;
	localparam int POS_W = 8;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_READ   = 3'd2;
	localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	// status codes
	localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
	localparam logic [ST_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [ST_W-1:0] STAT_RANGE = 2'd2;

	// sequencer states
	typedef enum logic {
		SQ_IDLE,
		SQ_CALC
	} seq_state_t;

	// per-cycle controls broadcast to every cell
	typedef struct packed {
		logic load;
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage

/* sv/ial_cell.sv */
// one list cell: holds an entry, shifts with its neighbors, flags match and selection
module ial_cell
	import ial_pkg::*;
#(
	parameter int DW  = 32,
	parameter int AW  = 7,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  cell_ctl_t     ctl,
	input  logic [AW-1:0] at,
	input  logic [AW-1:0] cnt,
	input  logic [DW-1:0] val,
	input  logic [DW-1:0] prev_data,
	input  logic [DW-1:0] next_data,
	output logic [DW-1:0] data,
	output logic          hit,
	output logic          sel
);

	localparam logic [AW-1:0] MY_IDX = AW'(IDX);

	logic [DW-1:0] data_q;
	logic          hit_q;
	logic          sel_q;

	// entry storage: shift up on insert, shift down on remove
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (MY_IDX > at) begin
				data_q <= prev_data;
			end else if (MY_IDX == at) begin
				data_q <= val;
			end
		end else if (ctl.rem) begin
			if (MY_IDX >= at) begin
				data_q <= next_data;
			end
		end
	end

	// match and position flags, taken from the list before the update
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			hit_q <= (data_q == val) && (MY_IDX < cnt);
			sel_q <= (MY_IDX == at);
		end
	end

	assign data = data_q;
	assign hit  = hit_q;
	assign sel  = sel_q;

endmodule

/* sv/ial_pick.sv */
// first-match encoder and selected-entry gather across the cell row
module ial_pick
	import ial_pkg::*;
#(
	parameter int N  = 64,
	parameter int DW = 32,
	parameter int IW = 6
) (
	input  logic [N-1:0]  hit,
	input  logic [N-1:0]  sel,
	input  logic [DW-1:0] data [N],
	output logic          any,
	output logic [IW-1:0] first_idx,
	output logic [DW-1:0] sel_data
);

	logic [N-1:0] first_oh;

	// isolate the lowest set match bit
	assign first_oh = hit & (~hit + N'(1));
	assign any      = |hit;

	// encode the one-hot match into an index
	always_comb begin
		first_idx = '0;
		for (int i = 0; i < N; i++) begin
			if (first_oh[i]) begin
				first_idx = first_idx | IW'(i);
			end
		end
	end

	// and-or gather of the selected entry
	always_comb begin
		sel_data = '0;
		for (int i = 0; i < N; i++) begin
			if (sel[i]) begin
				sel_data = sel_data | data[i];
			end
		end
	end

endmodule

/* sv/indexed_insert_remove_list_top.sv */
// top level of the indexed insert/remove list: cell row, sequencer and result registers
//
// channel  | handshake          | fields
// ---------+--------------------+----------------------------------------------------
// command  | start, busy        | op, position, value
// result   | done (one cycle)   | status, read_data, found_at, count_now,
//          |                    | empty_flag, full_flag
//
// on the accept edge the cell row updates and latches per-cell match flags;
// in the busy state the encoder picks the first match across the CAPACITY
// cells and the read entry is gathered into the result registers. done is
// registered from busy and pulses as the result word appears, and a new word
// can be accepted in that same cycle. busy is high for one cycle after each
// accept. reset clears the length and the sequencer; entry contents stay
// unknown until written. the receiver cannot stall.
module indexed_insert_remove_list_top
	import ial_pkg::*;
#(
	parameter int CAPACITY      = 64,
	parameter int ELEMENT_WIDTH = 32,
	localparam int CNT_W        = $clog2(CAPACITY + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [OP_W-1:0]         op,
	input  logic signed [POS_W-1:0] position,
	input  logic [VAL_W-1:0]        value,
	output logic                    done,
	output logic [ST_W-1:0]         status,
	output logic [VAL_W-1:0]        read_data,
	output logic signed [CNT_W-1:0] found_at,
	output logic [CNT_W-1:0]        count_now,
	output logic                    empty_flag,
	output logic                    full_flag
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_W = (CNT_W > POS_W - 1) ? CNT_W : POS_W - 1;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	seq_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [ST_W-1:0]  status_s1;
	logic             rd_ok_s1;
	logic             srch_s1;

	logic             accept;
	logic             is_ins, is_rem, is_rd, is_srch, is_clr;
	logic             is_full;
	logic             rng_ok;
	logic             ins_ok, rem_ok;
	logic [CMP_W-1:0] pos_c, cnt_c, at_c;
	cell_ctl_t        ctl;
	logic [ELEMENT_WIDTH-1:0] val_e;

	logic [ELEMENT_WIDTH-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]      cell_hit;
	logic [CAPACITY-1:0]      cell_sel;
	logic                     pick_any;
	logic [IDX_W-1:0]         pick_idx;
	logic [ELEMENT_WIDTH-1:0] pick_data;

	// command decode
	assign accept  = start && !busy;
	assign is_ins  = (op == OP_INSERT);
	assign is_rem  = (op == OP_REMOVE);
	assign is_rd   = (op == OP_READ);
	assign is_srch = (op == OP_SEARCH);
	assign is_clr  = (op == OP_CLEAR);
	assign is_full = (count_q == CAP_CNT);
	assign val_e   = ELEMENT_WIDTH'(value);

	// position checks against the current length
	assign pos_c  = CMP_W'(position[POS_W-2:0]);
	assign cnt_c  = CMP_W'(count_q);
	assign rng_ok = !position[POS_W-1] && (pos_c < cnt_c);
	assign ins_ok = is_ins && !is_full;
	assign rem_ok = is_rem && rng_ok;

	// insert past the end or at a negative position appends
	always_comb begin
		if (is_ins && (position[POS_W-1] || (pos_c > cnt_c))) begin
			at_c = cnt_c;
		end else begin
			at_c = pos_c;
		end
	end

	assign ctl.load = accept;
	assign ctl.ins  = accept && ins_ok;
	assign ctl.rem  = accept && rem_ok;

	// cell row
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [ELEMENT_WIDTH-1:0] prev_w, next_w;
		if (g == 0) begin : g_lo
			assign prev_w = cell_data[g];
		end else begin : g_lo_n
			assign prev_w = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_hi
			assign next_w = cell_data[g];
		end else begin : g_hi_n
			assign next_w = cell_data[g+1];
		end
		ial_cell #(
			.DW  (ELEMENT_WIDTH),
			.AW  (CMP_W),
			.IDX (g)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.at        (at_c),
			.cnt       (cnt_c),
			.val       (val_e),
			.prev_data (prev_w),
			.next_data (next_w),
			.data      (cell_data[g]),
			.hit       (cell_hit[g]),
			.sel       (cell_sel[g])
		);
	end

	// first match and read gather
	ial_pick #(
		.N  (CAPACITY),
		.DW (ELEMENT_WIDTH),
		.IW (IDX_W)
	) u_pick (
		.hit       (cell_hit),
		.sel       (cell_sel),
		.data      (cell_data),
		.any       (pick_any),
		.first_idx (pick_idx),
		.sel_data  (pick_data)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: begin
				if (start) begin
					state_d = SQ_CALC;
				end
			end
			SQ_CALC: begin
				state_d = SQ_IDLE;
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	assign busy = (state_q == SQ_CALC);

	// list length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (ins_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rem_ok) begin
				count_q <= count_q - CNT_W'(1);
			end else if (is_clr) begin
				count_q <= '0;
			end
		end
	end

	// command outcome held for the result stage
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_s1 <= is_rd && rng_ok;
			srch_s1  <= is_srch;
			if (is_ins && is_full) begin
				status_s1 <= STAT_FULL;
			end else if ((is_rem || is_rd) && !rng_ok) begin
				status_s1 <= STAT_RANGE;
			end else begin
				status_s1 <= STAT_OK;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= busy;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (busy) begin
			status     <= status_s1;
			read_data  <= rd_ok_s1 ? VAL_W'(pick_data) : '0;
			found_at   <= (srch_s1 && pick_any) ? CNT_W'(pick_idx) : '1;
			count_now  <= count_q;
			empty_flag <= (count_q == '0);
			full_flag  <= is_full;
		end
	end

endmodule

/* tb/ial_list_checker.sv */
// checker for the indexed insert/remove list: predicts each result word and compares it
`timescale 1ns / 1ps

module ial_list_checker
	import ial_pkg::*;
#(
	parameter int CAPACITY = 64,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [OP_W-1:0]         op,
	input  logic signed [POS_W-1:0] position,
	input  logic [VAL_W-1:0]        value,
	input  logic                    done,
	input  logic [ST_W-1:0]         status,
	input  logic [VAL_W-1:0]        read_data,
	input  logic signed [CNT_W-1:0] found_at,
	input  logic [CNT_W-1:0]        count_now,
	input  logic                    empty_flag,
	input  logic                    full_flag,
	output int                      mismatches,
	output int                      outstanding
);

	// one result word as the block should report it
	typedef struct packed {
		logic [ST_W-1:0]         status;
		logic [VAL_W-1:0]        read_data;
		logic signed [CNT_W-1:0] found_at;
		logic [CNT_W-1:0]        count_now;
		logic                    empty_flag;
		logic                    full_flag;
	} list_reply_t;

	// private copy of the list contents and length
	logic [VAL_W-1:0] list_copy [CAPACITY];
	int               list_len;
	list_reply_t      awaited_replies [$];

	initial mismatches = 0;
	initial outstanding = 0;

	// apply one command word to the private list and work out its result
	task automatic apply_list_op(input logic [OP_W-1:0] cmd,
			input logic signed [POS_W-1:0] pos, input logic [VAL_W-1:0] val,
			output list_reply_t rep);
		int p;
		int at;
		int i;
		p = int'(pos);
		rep.status    = STAT_OK;
		rep.read_data = '0;
		rep.found_at  = '1;
		case (cmd)
			OP_INSERT: begin
				if (list_len >= CAPACITY) begin
					rep.status = STAT_FULL;
				end else begin
					at = (p < 0 || p > list_len) ? list_len : p;
					for (i = list_len; i > at; i--)
						list_copy[i] = list_copy[i-1];
					list_copy[at] = val;
					list_len++;
				end
			end
			OP_REMOVE: begin
				if (p < 0 || p >= list_len) begin
					rep.status = STAT_RANGE;
				end else begin
					for (i = p; i + 1 < list_len; i++)
						list_copy[i] = list_copy[i+1];
					list_len--;
				end
			end
			OP_READ: begin
				if (p < 0 || p >= list_len)
					rep.status = STAT_RANGE;
				else
					rep.read_data = list_copy[p];
			end
			OP_SEARCH: begin
				for (i = 0; i < list_len; i++) begin
					if (list_copy[i] == val) begin
						rep.found_at = CNT_W'(i);
						break;
					end
				end
			end
			OP_CLEAR: begin
				list_len = 0;
			end
			default: begin
			end
		endcase
		rep.count_now  = CNT_W'(list_len);
		rep.empty_flag = (list_len == 0);
		rep.full_flag  = (list_len == CAPACITY);
	endtask

	// one field compare, counted and reported on mismatch
	task automatic check_field(input string name, input logic [VAL_W-1:0] want,
			input logic [VAL_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	// watch both channels at each edge
	always @(posedge clk or negedge arst_n) begin
		list_reply_t rep;
		if (!arst_n) begin
			list_len = 0;
			awaited_replies.delete();
		end else begin
			if (done) begin
				if (awaited_replies.size() == 0) begin
					$error("result word with no command outstanding");
					mismatches++;
				end else begin
					rep = awaited_replies.pop_front();
					check_field("status", VAL_W'(rep.status), VAL_W'(status));
					check_field("read_data", rep.read_data, read_data);
					check_field("found_at", VAL_W'(unsigned'(rep.found_at)),
						VAL_W'(unsigned'(found_at)));
					check_field("count_now", VAL_W'(rep.count_now), VAL_W'(count_now));
					check_field("empty_flag", VAL_W'(rep.empty_flag), VAL_W'(empty_flag));
					check_field("full_flag", VAL_W'(rep.full_flag), VAL_W'(full_flag));
				end
			end
			if (start && !busy) begin
				apply_list_op(op, position, value, rep);
				awaited_replies.push_back(rep);
			end
		end
		outstanding = awaited_replies.size();
	end

endmodule

/* tb/indexed_insert_remove_list_top_test.sv */
// testbench top for the indexed insert/remove list: clock, reset, command stimulus, verdict
`timescale 1ns / 1ps

module indexed_insert_remove_list_top_test;
	import ial_pkg::*;

	localparam int CAPACITY    = 64;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int RAND_ITEMS  = 1900;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 8;

	// op codes the block leaves unused
	localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

	// list growth modes for random bursts
	localparam int MODE_GROW   = 0;
	localparam int MODE_SHRINK = 1;
	localparam int MODE_MIXED  = 2;

	logic                    clk;
	logic                    arst_n   = 1'b0;
	logic                    start    = 1'b0;
	logic [OP_W-1:0]         op       = '0;
	logic signed [POS_W-1:0] position = '0;
	logic [VAL_W-1:0]        value    = '0;
	logic                    busy;
	logic                    done;
	logic [ST_W-1:0]         status;
	logic [VAL_W-1:0]        read_data;
	logic signed [CNT_W-1:0] found_at;
	logic [CNT_W-1:0]        count_now;
	logic                    empty_flag;
	logic                    full_flag;
	int                      mismatches;
	int                      outstanding;
	int                      cycle_cnt = 0;
	int                      list_len_seen = 0;
	logic                    calm = 1'b0;

	indexed_insert_remove_list_top #(
		.CAPACITY(CAPACITY)
	) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .position(position), .value(value),
		.done(done), .status(status), .read_data(read_data), .found_at(found_at),
		.count_now(count_now), .empty_flag(empty_flag), .full_flag(full_flag)
	);

	ial_list_checker #(
		.CAPACITY(CAPACITY)
	) u_list_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .position(position), .value(value),
		.done(done), .status(status), .read_data(read_data), .found_at(found_at),
		.count_now(count_now), .empty_flag(empty_flag), .full_flag(full_flag),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// values drawn often from a small set so searches find matches
	function automatic logic [VAL_W-1:0] pick_value();
		if ($urandom_range(99) < 50) begin
			case ($urandom_range(5))
				0: return 32'h0000_0000;
				1: return 32'hFFFF_FFFF;
				2: return 32'h0000_0001;
				3: return 32'h8000_0000;
				4: return 32'h0000_BEEF;
				default: return 32'h1234_5678;
			endcase
		end
		return $urandom;
	endfunction

	// positions mostly inside the list, the rest at or past its edges
	function automatic logic signed [POS_W-1:0] pick_pos(input logic [OP_W-1:0] cmd);
		int r;
		r = $urandom_range(99);
		if (cmd == OP_INSERT) begin
			if (r < 55) return POS_W'($urandom_range(list_len_seen, 0));
			if (r < 70) return POS_W'(-1);
			if (r < 85) return POS_W'(127);
			return POS_W'($urandom_range(127, 0));
		end
		if (list_len_seen > 0 && r < 65) return POS_W'($urandom_range(list_len_seen - 1, 0));
		if (r < 75) return POS_W'(-1);
		if (r < 85) return POS_W'(list_len_seen);
		return POS_W'($urandom_range(127, 0));
	endfunction

	// op mix per burst mode, with rare clears and unused codes
	function automatic logic [OP_W-1:0] pick_op(input int mode);
		int r;
		r = $urandom_range(99);
		if (r < 2) return OP_CLEAR;
		if (r < 3) begin
			case ($urandom_range(2))
				0: return OP_SPARE5;
				1: return OP_SPARE6;
				default: return OP_SPARE7;
			endcase
		end
		case (mode)
			MODE_GROW: begin
				if (r < 88) return OP_INSERT;
				if (r < 93) return OP_READ;
				if (r < 97) return OP_SEARCH;
				return OP_REMOVE;
			end
			MODE_SHRINK: begin
				if (r < 15) return OP_INSERT;
				if (r < 70) return OP_REMOVE;
				if (r < 85) return OP_READ;
				return OP_SEARCH;
			end
			default: begin
				if (r < 35) return OP_INSERT;
				if (r < 55) return OP_REMOVE;
				if (r < 78) return OP_READ;
				return OP_SEARCH;
			end
		endcase
	endfunction

	// send one command word, with random idle cycles ahead of it unless calm is set
	task automatic send_word(input logic [OP_W-1:0] cmd, input logic signed [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		int p;
		while (!calm && $urandom_range(99) < 21) begin
			start    <= 1'b0;
			op       <= OP_W'($urandom_range(7));
			position <= POS_W'($urandom);
			value    <= $urandom;
			@(posedge clk);
		end
		start    <= 1'b1;
		op       <= cmd;
		position <= pos;
		value    <= val;
		@(posedge clk);
		while (busy) @(posedge clk);
		// track the length only to aim positions
		p = int'(pos);
		case (cmd)
			OP_INSERT: if (list_len_seen < CAPACITY) list_len_seen++;
			OP_REMOVE: if (p >= 0 && p < list_len_seen) list_len_seen--;
			OP_CLEAR:  list_len_seen = 0;
			default: begin
			end
		endcase
	endtask

	initial begin
		int n;
		int burst_left;
		int mode;
		logic [OP_W-1:0] cmd;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: out-of-range read and remove, search with nothing stored
		send_word(OP_READ, POS_W'(0), 32'h0);
		send_word(OP_REMOVE, POS_W'(0), 32'h0);
		send_word(OP_SEARCH, POS_W'(0), 32'h0);
		// appends by negative and past-end position, inserts at head and middle
		send_word(OP_INSERT, POS_W'(-1), 32'h0000_0000);
		send_word(OP_INSERT, POS_W'(127), 32'hFFFF_FFFF);
		send_word(OP_INSERT, POS_W'(0), 32'h1234_5678);
		send_word(OP_INSERT, POS_W'(1), 32'hA5A5_A5A5);
		send_word(OP_INSERT, POS_W'(4), 32'h5A5A_5A5A);
		// reads at both ends and just outside
		send_word(OP_READ, POS_W'(0), 32'h0);
		send_word(OP_READ, POS_W'(4), 32'h0);
		send_word(OP_READ, POS_W'(5), 32'h0);
		send_word(OP_READ, POS_W'(-1), 32'h0);
		send_word(OP_READ, POS_W'(127), 32'h0);
		// search hit and miss
		send_word(OP_SEARCH, POS_W'(0), 32'hFFFF_FFFF);
		send_word(OP_SEARCH, POS_W'(0), 32'hDEAD_BEEF);
		// removes out of range, at head and at tail
		send_word(OP_REMOVE, POS_W'(-1), 32'h0);
		send_word(OP_REMOVE, POS_W'(127), 32'h0);
		send_word(OP_REMOVE, POS_W'(0), 32'h0);
		send_word(OP_REMOVE, POS_W'(3), 32'h0);
		// unused codes, then clear and append into the cleared list
		send_word(OP_SPARE5, POS_W'(0), 32'h0);
		send_word(OP_SPARE6, POS_W'(1), 32'hFFFF_FFFF);
		send_word(OP_SPARE7, POS_W'(127), 32'h0);
		send_word(OP_CLEAR, POS_W'(0), 32'h0);
		send_word(OP_INSERT, POS_W'(2), 32'h0000_BEEF);
		send_word(OP_CLEAR, POS_W'(-1), 32'hFFFF_FFFF);

		// random bursts that fill, drain and churn the list
		n = 0;
		burst_left = 0;
		mode = MODE_GROW;
		while (n < RAND_ITEMS) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(80, 10);
				mode = $urandom_range(2, 0);
			end
			calm = (n >= 700 && n < 1000);
			cmd = pick_op(mode);
			send_word(cmd, pick_pos(cmd), pick_value());
			burst_left--;
			n++;
		end
		start <= 1'b0;
		@(posedge clk);

		// wait for the last result words, then a few more cycles
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
sv/ial_pkg.sv
sv/ial_cell.sv
sv/ial_pick.sv
sv/indexed_insert_remove_list_top.sv
tb/ial_list_checker.sv
tb/indexed_insert_remove_list_top_test.sv
